// ===== hw/rtl/lcg_ohlc_bar_generator_unit_defines.svh =====
// Assertion macros shared by the bar generator RTL.
// Included by the top level; depends on nothing else.
`ifndef LCG_OHLC_BAR_GENERATOR_UNIT_DEFINES_SVH
`define LCG_OHLC_BAR_GENERATOR_UNIT_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define LCGBAR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked in every cycle, reset included.
`define LCGBAR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/lcgbar_pkg.sv =====
// Shared types, widths and constants of the bar generator.
// Used by every RTL module of the block; depends on nothing.
`default_nettype none

package lcgbar_pkg;

   localparam int BARS_PER_SESSION = 120;

   localparam int SEED_W  = 32;
   localparam int DAY_W   = 40;
   localparam int IDX_W   = 8;
   localparam int PRICE_W = 22;
   localparam int TIME_W  = 41;
   localparam int DRAW_W  = 15;
   localparam int DRAW_LSB = 16;

   // Bar index width used for saturation, wide enough for the last bar and the raw index.
   localparam int CMP_W  = $clog2(2 * BARS_PER_SESSION) + 1 > IDX_W
                           ? $clog2(2 * BARS_PER_SESSION) + 1 : IDX_W;
   // Width of the one-based bar number within a session.
   localparam int SESS_W = $clog2(BARS_PER_SESSION + 1);

   localparam logic [SEED_W-1:0]  LCG_MUL    = 32'd1103515245;
   localparam logic [SEED_W-1:0]  LCG_ADD    = 32'd12345;
   localparam logic [PRICE_W-1:0] PRICE_BASE = 22'd2949120;
   localparam logic [TIME_W-1:0]  MORNING_OFFSET   = 41'd34200;
   localparam logic [TIME_W-1:0]  AFTERNOON_OFFSET = 41'd46800;

   localparam logic [CMP_W-1:0] LAST_BAR    = CMP_W'(2 * BARS_PER_SESSION - 1);
   localparam logic [CMP_W-1:0] SESSION_LEN = CMP_W'(BARS_PER_SESSION);

   typedef struct packed {
      logic load;      // copy the seed into the generator state
      logic advance;   // take one generator step
   } lcg_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lcgbar_lcg_unit.sv =====
// Shared generator unit: holds the 32-bit LCG state and its single multiplier.
// Depends on lcgbar_pkg.
`default_nettype none

module lcgbar_lcg_unit
   import lcgbar_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lcg_ctl_type       ctl,
   input  wire logic [SEED_W-1:0] seed,
   output logic      [SEED_W-1:0] state
);

   logic [SEED_W-1:0] state_ff;
   logic [SEED_W-1:0] state_in;
   logic [SEED_W-1:0] stepped;

   // Low 32 bits of the product only: the state wraps modulo 2^32.
   assign stepped = state_ff * LCG_MUL + LCG_ADD;

   always_comb begin
      state_in = state_ff;
      if (ctl.load) begin
         state_in = seed;
      end else if (ctl.advance) begin
         state_in = stepped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lcgbar_time_unit.sv =====
// End-of-bar timestamp unit: saturates the bar index, picks the session and
// registers day_start + session offset + 60 * bar number. Depends on lcgbar_pkg.
`default_nettype none

module lcgbar_time_unit
   import lcgbar_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire logic [DAY_W-1:0]  day_start,
   input  wire logic [IDX_W-1:0]  bar_index,
   output logic      [TIME_W-1:0] end_time
);

   logic [TIME_W-1:0] end_time_ff;
   logic [TIME_W-1:0] end_time_in;
   logic [CMP_W-1:0]  idx_wide;
   logic [CMP_W-1:0]  idx_sat;
   logic [CMP_W-1:0]  idx_sess;
   logic [SESS_W-1:0] bar_num;
   logic [TIME_W-1:0] bar_num_w;
   logic              morning;

   always_comb begin
      idx_wide  = CMP_W'(bar_index);
      idx_sat   = (idx_wide > LAST_BAR) ? LAST_BAR : idx_wide;
      morning   = idx_sat < SESSION_LEN;
      idx_sess  = morning ? idx_sat : idx_sat - SESSION_LEN;
      bar_num   = SESS_W'(idx_sess) + SESS_W'(1);
      bar_num_w = TIME_W'(bar_num);
      // 60 * n as 64 * n - 4 * n.
      end_time_in = TIME_W'(day_start)
                  + (morning ? MORNING_OFFSET : AFTERNOON_OFFSET)
                  + (bar_num_w << 6) - (bar_num_w << 2);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         end_time_ff <= end_time_in;
      end
   end

   assign end_time = end_time_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lcg_ohlc_bar_generator_unit.sv =====
// Top level of the synthetic OHLC bar generator: sequencer, price registers,
// output register and assertions. Depends on lcgbar_pkg, lcgbar_lcg_unit,
// lcgbar_time_unit and lcg_ohlc_bar_generator_unit_defines.svh.
//
// One request transfer yields one bar. The block draws four values from a
// 32-bit ANSI-style LCG through a single shared multiplier, one step per
// cycle, and builds open, close, low and high from them in that order; the
// end-of-bar timestamp is computed in parallel. A result becomes valid after
// its request transfer has passed the sequencer run (four generator steps,
// each draw registered before its price is formed), the hold state and the
// load of the output register. req_tready is high only while the sequencer
// is idle, which it is again from the cycle in which the result appears, so
// the block takes no new request while a bar is being built or held; a
// finished bar waits in the sequencer until the output register is free.
// Writing csr_wr_data does not change the generator state; the seed is
// loaded only by a request with restart set. There is no clearing pass
// after reset.
`default_nettype none

`include "lcg_ohlc_bar_generator_unit_defines.svh"

module lcg_ohlc_bar_generator_unit
   import lcgbar_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,

   // Configuration: initial_seed.
   input  wire logic          csr_wr_en,
   input  wire logic [31:0]   csr_wr_data,

   // Request channel.
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [47:0]   req_tdata,   // day_start[39:0], bar_index[47:40]
   input  wire logic          req_tuser,   // restart

   // Result channel.
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // open_price[21:0], high_price[43:22], low_price[65:44], close_price[87:66],
   // end_time[128:88], zero fill[135:129]
   output logic [135:0]       rsp_tdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   // Sequencer step numbers within ST_RUN.
   localparam logic [2:0] STEP_OPEN  = 3'd1;
   localparam logic [2:0] STEP_CLOSE = 3'd2;
   localparam logic [2:0] STEP_LOW   = 3'd3;
   localparam logic [2:0] STEP_HIGH  = 3'd4;

   state_type          state_ff, state_in;
   logic [2:0]         step_ff, step_in;
   logic [SEED_W-1:0]  seed_ff;
   logic [DAY_W-1:0]   day_ff;
   logic [IDX_W-1:0]   bar_ff;
   logic [PRICE_W-1:0] open_ff, close_ff, low_ff, high_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [135:0]       rsp_data_ff;

   lcg_ctl_type        lcg_ctl;
   logic [SEED_W-1:0]  lcg_state;
   logic [DRAW_W-1:0]  draw;
   logic [PRICE_W-1:0] draw_w;
   logic [PRICE_W-1:0] scaled_price;
   logic [PRICE_W-1:0] min_price, max_price;
   logic [TIME_W-1:0]  end_time;
   logic               req_xfer;
   logic               out_free;
   logic               out_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = (state_ff == ST_HOLD) && out_free;

   // The draw is bits 30..16 of the state left by the previous step.
   assign draw         = lcg_state[DRAW_LSB +: DRAW_W];
   assign draw_w       = PRICE_W'(draw);
   assign scaled_price = PRICE_BASE + (draw_w << 4) + (draw_w << 2);
   assign min_price    = (open_ff < close_ff) ? open_ff : close_ff;
   assign max_price    = (open_ff < close_ff) ? close_ff : open_ff;

   always_comb begin
      lcg_ctl.load    = req_xfer && req_tuser;
      lcg_ctl.advance = (state_ff == ST_RUN) && (step_ff < STEP_HIGH);
   end

   lcgbar_lcg_unit u_lcg (
      .clock (clock),
      .reset (reset),
      .ctl   (lcg_ctl),
      .seed  (seed_ff),
      .state (lcg_state)
   );

   lcgbar_time_unit u_time (
      .clock     (clock),
      .enable    ((state_ff == ST_RUN) && (step_ff == STEP_OPEN)),
      .day_start (day_ff),
      .bar_index (bar_ff),
      .end_time  (end_time)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_xfer) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 3'd1;
            if (step_ff == STEP_HIGH) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         seed_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
      end
   end

   // Request capture and price registers.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         day_ff <= req_tdata[39:0];
         bar_ff <= req_tdata[47:40];
      end
      if (state_ff == ST_RUN) begin
         case (step_ff)
            STEP_OPEN:  open_ff  <= scaled_price;
            STEP_CLOSE: close_ff <= scaled_price;
            STEP_LOW:   low_ff   <= min_price - (draw_w << 1);
            STEP_HIGH:  high_ff  <= max_price + (draw_w << 1);
            default:    ;
         endcase
      end
   end

   // Output register: a finished bar moves in once the previous result is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {7'd0, end_time, close_ff, low_ff, high_ff, open_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A request transfer always starts the sequencer at its first step.
   `LCGBAR_ASSERT(a_xfer_starts_run, clock, reset, req_xfer |=> (state_ff == ST_RUN && step_ff == 3'd0), "request transfer did not start the sequencer")

   // A finished bar with a free output register becomes a valid result next cycle.
   `LCGBAR_ASSERT(a_hold_loads_output, clock, reset, out_load |=> (rsp_tvalid && state_ff == ST_IDLE), "finished bar was not moved to the output")

   // Every delivered bar has its low at or below its high.
   `LCGBAR_ASSERT(a_low_not_above_high, clock, reset, rsp_tvalid |-> (rsp_tdata[65:44] <= rsp_tdata[43:22]), "result low price above high price")

   // The generator never steps outside the sequencer run.
   `LCGBAR_ASSERT_ALWAYS(a_advance_only_running, clock, lcg_ctl.advance |-> (state_ff == ST_RUN), "generator stepped outside a run")

endmodule

`default_nettype wire
